/* hdl/bbe_pkg.sv */
// Shared types and constants for the B-spline basis evaluator.
// Command codes, register indexes and the request/response structs of the serial divider.
// No dependencies.
`timescale 1ns / 1ps
package bbe_pkg;

	localparam logic [1:0] CMD_LOAD_KNOT = 2'd0;
	localparam logic [1:0] CMD_LOAD_COEF = 2'd1;
	localparam logic [1:0] CMD_EVAL_ONE  = 2'd2;
	localparam logic [1:0] CMD_EVAL_ALL  = 2'd3;

	localparam logic REG_DEGREE = 1'b0;
	localparam logic REG_NPTS   = 1'b1;

	// Dividend is a 33-bit magnitude shifted up by the 24 fraction bits.
	localparam int DIV_DEN_W = 33;
	localparam int DIV_NUM_W = DIV_DEN_W + 24;

	typedef struct packed {
		logic                 start;
		logic                 neg;
		logic [DIV_NUM_W-1:0] num_mag;
		logic [DIV_DEN_W-1:0] den_mag;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic signed [31:0] quot;
	} div_rsp_t;

endpackage

/* hdl/bbe_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module bbe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hdl/bbe_div.sv */
// Restoring divider, one quotient bit per cycle, with signed saturation
// of the quotient to 32 bits. Depends on bbe_pkg.
`timescale 1ns / 1ps
module bbe_div
	import bbe_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(DIV_NUM_W + 1);

	logic                 busy_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DIV_NUM_W-1:0] num_q;
	logic [DIV_NUM_W-1:0] quot_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic                 neg_q;
	logic                 done_q;
	logic signed [31:0]   res_q;

	logic [DIV_DEN_W:0]   rem_sh;
	logic                 fits;
	logic [DIV_NUM_W-1:0] quot_n;

	assign rem_sh = {rem_q, num_q[DIV_NUM_W-1]};
	assign fits   = rem_sh >= {1'b0, den_q};
	assign quot_n = {quot_q[DIV_NUM_W-2:0], fits};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q  <= req.num_mag;
			den_q  <= req.den_mag;
			neg_q  <= req.neg;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q  <= {num_q[DIV_NUM_W-2:0], 1'b0};
			rem_q  <= fits ? DIV_DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DIV_DEN_W-1:0];
			quot_q <= quot_n;
			if (cnt_q == CNT_W'(1)) begin
				// Truncation toward zero, then clamp to the signed 32-bit range.
				if (neg_q) begin
					if (quot_n > DIV_NUM_W'(33'h080000000)) begin
						res_q <= 32'sh80000000;
					end else begin
						res_q <= 32'(-quot_n);
					end
				end else begin
					if (quot_n > DIV_NUM_W'(33'h07fffffff)) begin
						res_q <= 32'sh7fffffff;
					end else begin
						res_q <= 32'(quot_n);
					end
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = res_q;

endmodule

/* hdl/bspline_basis_evaluation_top.sv */
// B-spline basis evaluator top level: sequencer, knot and coefficient RAMs,
// shared multiplier for Horner steps. Depends on bbe_pkg, bbe_ram, bbe_div.
`timescale 1ns / 1ps
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------
//  in      | input     | in_valid / in_ready  | cmd, knot_index ... basis_index
//  out     | output    | out_valid / out_ready| basis_func, basis_value, span_found,
//          |           |                      | range_error, last
//  cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// A load is written as it is accepted. An evaluation reads the range knots, runs the
// binary search, counts the segments and reads the upper knot over the single knot RAM
// read port, then runs the serial divider (skipped on an empty span) and sets up; each
// result is then built by Horner steps through the shared multiplier and the coefficient
// RAM port. Reset idles the sequencer, sets degree 3 and npts 4 and clears the output
// beat; both tables are undefined until loaded. A stalled output beat holds the
// sequencer before its next result.
module bspline_basis_evaluation_top
	import bbe_pkg::*;
#(
	parameter int MAX_KNOTS  = 64,
	parameter int MAX_DEGREE = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [5:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic [5:0]         knot_index,
	input  logic signed [31:0] knot_value,
	input  logic [5:0]         segment,
	input  logic [1:0]         func_slot,
	input  logic [1:0]         power,
	input  logic signed [31:0] coef_value,
	input  logic signed [31:0] node,
	input  logic [5:0]         basis_index,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [5:0]         basis_func,
	output logic signed [31:0] basis_value,
	output logic [5:0]         span_found,
	output logic               range_error,
	output logic               last
);

	localparam int SLOTS     = MAX_DEGREE + 1;
	localparam int KAW       = $clog2(MAX_KNOTS);
	localparam int CDEPTH    = 64 * SLOTS * SLOTS;
	localparam int CAW       = $clog2(CDEPTH);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_LOQ  = 4'd1;
	localparam logic [3:0] ST_HIQ  = 4'd2;
	localparam logic [3:0] ST_BS   = 4'd3;
	localparam logic [3:0] ST_BSW  = 4'd4;
	localparam logic [3:0] ST_SEG0 = 4'd5;
	localparam logic [3:0] ST_SEGW = 4'd6;
	localparam logic [3:0] ST_KHI  = 4'd7;
	localparam logic [3:0] ST_DIVW = 4'd8;
	localparam logic [3:0] ST_PREP = 4'd9;
	localparam logic [3:0] ST_HRD  = 4'd10;
	localparam logic [3:0] ST_HADD = 4'd11;
	localparam logic [3:0] ST_OUT  = 4'd12;

	function automatic logic signed [31:0] sat32(input logic signed [40:0] x);
		if (x > 41'sh007fffffff) begin
			return 32'sh7fffffff;
		end else if (x < -41'sh0080000000) begin
			return 32'sh80000000;
		end
		return 32'(x);
	endfunction

	logic [3:0]         state_q;
	logic [1:0]         degree_q;
	logic [5:0]         npts_q;
	logic [1:0]         cmd_q;
	logic signed [31:0] nd_q;
	logic [5:0]         bi_q;
	logic [1:0]         deg_q;
	logic [5:0]         ne_q;
	logic signed [31:0] klo_q;
	logic signed [31:0] prev_q;
	logic               err_q;
	logic [5:0]         lo_q;
	logic [5:0]         hi_q;
	logic [5:0]         mid_q;
	logic [5:0]         s_q;
	logic [5:0]         i_q;
	logic [5:0]         seg_q;
	logic signed [31:0] v_q;
	logic [1:0]         slot_q;
	logic [1:0]         p_q;
	logic signed [31:0] acc_q;
	logic signed [63:0] prod_q;
	logic               koob_q;
	logic               out_valid_q;

	logic [1:0]         deg_c;
	logic [5:0]         ne_c;
	logic               accept;
	logic [5:0]         kaddr;
	logic [31:0]        kram_q;
	logic signed [31:0] kd;
	logic [6:0]         mid_sum;
	logic signed [32:0] dlt;
	logic signed [32:0] den;
	logic [32:0]        dlt_mag;
	logic [32:0]        den_mag;
	logic [31:0]        cram_q;
	logic [CAW-1:0]     caddr_w;
	logic [CAW-1:0]     caddr_r;
	logic               kwe;
	logic               cwe;
	logic signed [7:0]  win;
	logic signed [31:0] acc_n;
	logic               out_free;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	assign deg_c = (int'(degree_q) > MAX_DEGREE) ? 2'(MAX_DEGREE) : degree_q;
	assign ne_c  = (npts_q < 6'(deg_c) + 6'd1) ? 6'(deg_c) + 6'd1 : npts_q;

	assign in_ready = state_q == ST_IDLE;
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= 2'd3;
			npts_q   <= 6'd4;
		end else if (cfg_we) begin
			if (cfg_index == REG_NPTS) begin
				npts_q <= cfg_data;
			end else begin
				degree_q <= cfg_data[1:0];
			end
		end
	end

	// Knot table; reads beyond the table size return zero.
	assign kwe = accept && cmd == CMD_LOAD_KNOT && int'(knot_index) < MAX_KNOTS;

	bbe_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_knot_ram (
		.clk   (clk),
		.we    (kwe),
		.waddr (KAW'(knot_index)),
		.wdata (knot_value),
		.raddr (KAW'(kaddr)),
		.rdata (kram_q)
	);

	always_ff @(posedge clk) begin
		koob_q <= int'(kaddr) >= MAX_KNOTS;
	end

	assign kd = koob_q ? 32'sd0 : $signed(kram_q);

	assign cwe = accept && cmd == CMD_LOAD_COEF &&
		int'(func_slot) <= MAX_DEGREE && int'(power) <= MAX_DEGREE;
	assign caddr_w = CAW'((int'(segment) * SLOTS + int'(func_slot)) * SLOTS + int'(power));
	assign caddr_r = CAW'((int'(seg_q) * SLOTS + int'(slot_q)) * SLOTS + int'(p_q));

	bbe_ram #(.WIDTH(32), .DEPTH(CDEPTH)) u_coef_ram (
		.clk   (clk),
		.we    (cwe),
		.waddr (caddr_w),
		.wdata (coef_value),
		.raddr (caddr_r),
		.rdata (cram_q)
	);

	assign mid_sum = 7'(lo_q) + 7'(hi_q);
	assign dlt     = {nd_q[31], nd_q} - {prev_q[31], prev_q};
	assign den     = {kd[31], kd} - {prev_q[31], prev_q};
	assign dlt_mag = dlt[32] ? 33'(-dlt) : 33'(dlt);
	assign den_mag = den[32] ? 33'(-den) : 33'(den);

	assign div_req.start   = state_q == ST_KHI && kd != prev_q;
	assign div_req.neg     = dlt[32] ^ den[32];
	assign div_req.num_mag = {dlt_mag, 24'd0};
	assign div_req.den_mag = den_mag;

	bbe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Slot of the requested function inside the nonzero window.
	assign win = $signed({2'b00, bi_q}) + $signed({6'd0, deg_q}) - $signed({2'b00, s_q});

	assign acc_n = sat32(41'(sat32(41'($signed(prod_q[63:24])))) + 41'($signed(cram_q)));

	always_comb begin
		kaddr = '0;
		unique case (state_q)
			ST_IDLE: kaddr = 6'(deg_c);
			ST_LOQ:  kaddr = ne_q;
			ST_HIQ:  kaddr = 6'(deg_q);
			ST_BS:   kaddr = (hi_q - lo_q > 6'd1) ? mid_sum[6:1] : 6'(deg_q);
			ST_SEG0: kaddr = (i_q < s_q) ? i_q + 6'd1 : s_q + 6'd1;
			ST_SEGW: kaddr = (i_q + 6'd1 < s_q) ? i_q + 6'd2 : s_q + 6'd1;
			default: kaddr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (cmd == CMD_EVAL_ONE || cmd == CMD_EVAL_ALL)) begin
						state_q <= ST_LOQ;
					end
				end
				ST_LOQ: state_q <= ST_HIQ;
				ST_HIQ: state_q <= (nd_q == kd) ? ST_SEG0 : ST_BS;
				ST_BS:  state_q <= (hi_q - lo_q > 6'd1) ? ST_BSW : ST_SEG0;
				ST_BSW: state_q <= ST_BS;
				ST_SEG0: state_q <= (i_q < s_q) ? ST_SEGW : ST_KHI;
				ST_SEGW: state_q <= (i_q + 6'd1 < s_q) ? ST_SEGW : ST_KHI;
				ST_KHI:  state_q <= (kd != prev_q) ? ST_DIVW : ST_PREP;
				ST_DIVW: state_q <= div_rsp.done ? ST_PREP : ST_DIVW;
				ST_PREP: begin
					if (err_q || (cmd_q == CMD_EVAL_ONE &&
						(win < 8'sd0 || win > $signed({6'd0, deg_q})))) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_HRD;
					end
				end
				ST_HRD:  state_q <= ST_HADD;
				ST_HADD: state_q <= (p_q == 2'd0) ? ST_OUT : ST_HRD;
				ST_OUT: begin
					if (out_free) begin
						if (cmd_q == CMD_EVAL_ALL && slot_q != deg_q) begin
							state_q <= err_q ? ST_OUT : ST_HRD;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				cmd_q <= cmd;
				nd_q  <= node;
				bi_q  <= basis_index;
				deg_q <= deg_c;
				ne_q  <= ne_c;
			end
			ST_LOQ: klo_q <= kd;
			ST_HIQ: begin
				err_q <= nd_q < klo_q || nd_q > kd;
				// The last knot itself belongs to the final span.
				s_q   <= ne_q - 6'd1;
				lo_q  <= 6'(deg_q);
				hi_q  <= ne_q;
				i_q   <= 6'(deg_q);
				seg_q <= '0;
			end
			ST_BS: begin
				mid_q <= mid_sum[6:1];
				if (hi_q - lo_q <= 6'd1) begin
					s_q <= lo_q;
				end
			end
			ST_BSW: begin
				if (nd_q < kd) begin
					hi_q <= mid_q;
				end else begin
					lo_q <= mid_q;
				end
			end
			ST_SEG0: prev_q <= kd;
			ST_SEGW: begin
				if (kd != prev_q) begin
					seg_q <= seg_q + 6'd1;
				end
				prev_q <= kd;
				i_q    <= i_q + 6'd1;
			end
			ST_KHI: v_q <= 32'sd0;
			ST_DIVW: begin
				if (div_rsp.done) begin
					v_q <= div_rsp.quot;
				end
			end
			ST_PREP: begin
				acc_q  <= 32'sd0;
				p_q    <= deg_q;
				slot_q <= (cmd_q == CMD_EVAL_ONE) ? win[1:0] : 2'd0;
			end
			ST_HRD: prod_q <= acc_q * v_q;
			ST_HADD: begin
				acc_q <= acc_n;
				p_q   <= p_q - 2'd1;
			end
			ST_OUT: begin
				if (out_free) begin
					basis_func  <= (cmd_q == CMD_EVAL_ONE) ? bi_q :
						s_q - 6'(deg_q) + 6'(slot_q);
					basis_value <= acc_q;
					span_found  <= s_q;
					range_error <= err_q;
					last        <= cmd_q == CMD_EVAL_ONE || slot_q == deg_q;
					acc_q       <= 32'sd0;
					p_q         <= deg_q;
					slot_q      <= slot_q + 2'd1;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;

	a_eval_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (cmd == CMD_EVAL_ONE || cmd == CMD_EVAL_ALL) |=> !in_ready)
		else $error("input taken while an evaluation starts");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_error |-> basis_value == 32'sd0)
		else $error("nonzero basis value on an out-of-range node");

	a_not_last_all: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> cmd_q == CMD_EVAL_ALL)
		else $error("open beat outside an evaluate-all");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DIVW)
		else $error("divider finished outside its wait state");

endmodule
